// ----- rtl/s2e_pkg.sv -----
// shared types, widths and constants for the symmetric 2x2 eigen solver
// no dependencies; the interfaces, s2e_eigvec and the core refer to this package by scoped names
package s2e_pkg;

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned VEC_W       = 16;
    localparam int unsigned FRAC_Q14    = 14;
    localparam int unsigned ONE_Q14     = 16384;
    localparam int unsigned NORM_QUO_W  = 15;
    localparam int unsigned CAND_W      = 33;
    localparam int unsigned E1_W        = 35;
    localparam int unsigned E1_MAG_W    = 34;
    localparam int unsigned RATIO_CLAMP_W = 41;
    localparam int unsigned RATIO_SCALE = 10000;
    localparam int unsigned RATIO_LO    = 9999;
    localparam int unsigned RATIO_HI    = 10001;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [VEC_W-1:0]  vec_t;
    typedef logic signed [CAND_W-1:0] cand_t;
    typedef logic [CAND_W-1:0]        cand_mag_t;

    function automatic data_t sat32(input logic signed [63:0] v);
        data_t r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = -32'sh8000_0000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    function automatic cand_mag_t mag33(input cand_t v);
        cand_mag_t r;
        r = v[CAND_W-1] ? cand_mag_t'(-v) : cand_mag_t'(v);
        return r;
    endfunction

endpackage

// ----- rtl/s2e_ifs.sv -----
// valid/ready channel interfaces for the matrix input and the eigen result
// depends on s2e_pkg
interface s2e_in_if;
    logic          valid;
    logic          ready;
    s2e_pkg::data_t var_x;
    s2e_pkg::data_t cov_xy;
    s2e_pkg::data_t var_y;
    modport source (output valid, output var_x, output cov_xy, output var_y, input ready);
    modport sink (input valid, input var_x, input cov_xy, input var_y, output ready);
endinterface

interface s2e_out_if;
    logic          valid;
    logic          ready;
    s2e_pkg::data_t eigen_first;
    s2e_pkg::data_t eigen_second;
    s2e_pkg::vec_t  vec_first_x;
    s2e_pkg::vec_t  vec_first_y;
    s2e_pkg::vec_t  vec_second_x;
    s2e_pkg::vec_t  vec_second_y;
    logic          used_fallback;
    modport source (output valid, output eigen_first, output eigen_second,
                    output vec_first_x, output vec_first_y, output vec_second_x,
                    output vec_second_y, output used_fallback, input ready);
    modport sink (input valid, input eigen_first, input eigen_second,
                  input vec_first_x, input vec_first_y, input vec_second_x,
                  input vec_second_y, input used_fallback, output ready);
endinterface

// ----- rtl/s2e_isqrt_pipe.sv -----
// pipelined floor square root, one root bit per register stage
// standalone; carries a sideband payload alongside the radicand
module s2e_isqrt_pipe #(
    parameter int unsigned IN_W  = 64,
    parameter int unsigned PAY_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     radicand,
    input  logic [PAY_W-1:0]    pay_in,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   root,
    output logic [PAY_W-1:0]    pay_out
);

    localparam int unsigned OUT_W = IN_W / 2;
    localparam int unsigned REM_W = OUT_W + 3;

    logic [OUT_W-1:0] val_reg;
    logic [IN_W-1:0]  rad_reg  [OUT_W];
    logic [REM_W-1:0] rem_reg  [OUT_W];
    logic [OUT_W-1:0] root_reg [OUT_W];
    logic [PAY_W-1:0] pay_reg  [OUT_W];

    genvar g;
    generate
        for (g = 0; g < OUT_W; g++)
        begin : g_stage
            logic             val_src;
            logic [IN_W-1:0]  rad_src;
            logic [REM_W-1:0] rem_src;
            logic [OUT_W-1:0] root_src;
            logic [PAY_W-1:0] pay_src;
            logic [REM_W-1:0] shifted;
            logic [REM_W-1:0] trial;
            logic             ge;

            if (g == 0)
            begin : g_first
                assign val_src  = in_valid;
                assign rad_src  = radicand;
                assign rem_src  = '0;
                assign root_src = '0;
                assign pay_src  = pay_in;
            end
            else
            begin : g_rest
                assign val_src  = val_reg[g-1];
                assign rad_src  = rad_reg[g-1];
                assign rem_src  = rem_reg[g-1];
                assign root_src = root_reg[g-1];
                assign pay_src  = pay_reg[g-1];
            end

            assign shifted = {rem_src[REM_W-3:0], rad_src[IN_W-1 -: 2]};
            assign trial   = REM_W'({root_src, 2'b01});
            assign ge      = (shifted >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    val_reg[g] <= 1'b0;
                else if (en)
                    val_reg[g] <= val_src;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[g]  <= rad_src << 2;
                    rem_reg[g]  <= ge ? shifted - trial : shifted;
                    root_reg[g] <= {root_src[OUT_W-2:0], ge};
                    pay_reg[g]  <= pay_src;
                end
            end
        end
    endgenerate

    assign out_valid = val_reg[OUT_W-1];
    assign root      = root_reg[OUT_W-1];
    assign pay_out   = pay_reg[OUT_W-1];

endmodule

// ----- rtl/s2e_div_pipe.sv -----
// pipelined unsigned restoring divider, one quotient bit per register stage
// standalone; caller supplies the upper dividend bits already below the divisor
module s2e_div_pipe #(
    parameter int unsigned DEN_W = 32,
    parameter int unsigned QUO_W = 16,
    parameter int unsigned PAY_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  rem_in,
    input  logic [QUO_W-1:0]  num_in,
    input  logic [DEN_W-1:0]  den_in,
    input  logic [PAY_W-1:0]  pay_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [PAY_W-1:0]  pay_out
);

    logic [QUO_W-1:0] val_reg;
    logic [DEN_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] num_reg [QUO_W];
    logic [DEN_W-1:0] den_reg [QUO_W];
    logic [PAY_W-1:0] pay_reg [QUO_W];

    genvar g;
    generate
        for (g = 0; g < QUO_W; g++)
        begin : g_stage
            logic             val_src;
            logic [DEN_W-1:0] rem_src;
            logic [QUO_W-1:0] num_src;
            logic [DEN_W-1:0] den_src;
            logic [PAY_W-1:0] pay_src;
            logic [DEN_W:0]   shifted;
            logic [DEN_W:0]   diff;
            logic             ge;

            if (g == 0)
            begin : g_first
                assign val_src = in_valid;
                assign rem_src = rem_in;
                assign num_src = num_in;
                assign den_src = den_in;
                assign pay_src = pay_in;
            end
            else
            begin : g_rest
                assign val_src = val_reg[g-1];
                assign rem_src = rem_reg[g-1];
                assign num_src = num_reg[g-1];
                assign den_src = den_reg[g-1];
                assign pay_src = pay_reg[g-1];
            end

            assign shifted = {rem_src, num_src[QUO_W-1]};
            assign diff    = shifted - {1'b0, den_src};
            assign ge      = (shifted >= {1'b0, den_src});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    val_reg[g] <= 1'b0;
                else if (en)
                    val_reg[g] <= val_src;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g] <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                    num_reg[g] <= {num_src[QUO_W-2:0], ge};
                    den_reg[g] <= den_src;
                    pay_reg[g] <= pay_src;
                end
            end
        end
    endgenerate

    assign out_valid = val_reg[QUO_W-1];
    assign quo       = num_reg[QUO_W-1];
    assign pay_out   = pay_reg[QUO_W-1];

endmodule

// ----- rtl/s2e_eigvec.sv -----
// eigenvector for one eigenvalue: candidate choice, normalisation, unit scaling
// depends on s2e_pkg, s2e_isqrt_pipe and s2e_div_pipe
module s2e_eigvec #(
    parameter int unsigned PAY_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  s2e_pkg::data_t    a,
    input  s2e_pkg::data_t    b,
    input  s2e_pkg::data_t    c,
    input  s2e_pkg::data_t    lam,
    input  logic [PAY_W-1:0]  pay_in,
    output logic              out_valid,
    output s2e_pkg::vec_t     vec_x,
    output s2e_pkg::vec_t     vec_y,
    output logic [PAY_W-1:0]  pay_out
);

    localparam int unsigned NQ = s2e_pkg::NORM_QUO_W;

    typedef struct packed {
        logic [30:0]      ux;
        logic [30:0]      uy;
        logic             negx;
        logic             negy;
        logic             zero;
        logic [PAY_W-1:0] pay;
    } sq_pay_t;

    typedef struct packed {
        logic             negx;
        logic             zero;
        logic [PAY_W-1:0] pay;
    } dx_pay_t;

    // candidates
    logic              v1_reg;
    s2e_pkg::cand_t    x1_reg, y1_reg, x2_reg, y2_reg;
    s2e_pkg::cand_mag_t m0_reg, m1_reg, m2_reg, m3_reg;
    logic [PAY_W-1:0]  p1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    s2e_pkg::cand_t x1_next, y1_next, x2_next, y2_next;
    assign x1_next = -(s2e_pkg::cand_t'(b));
    assign y1_next = s2e_pkg::cand_t'(a) - s2e_pkg::cand_t'(lam);
    assign x2_next = s2e_pkg::cand_t'(lam) - s2e_pkg::cand_t'(c);
    assign y2_next = s2e_pkg::cand_t'(b);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            x2_reg <= x2_next;
            y2_reg <= y2_next;
            m0_reg <= s2e_pkg::mag33(x1_next);
            m1_reg <= s2e_pkg::mag33(y1_next);
            m2_reg <= s2e_pkg::mag33(x2_next);
            m3_reg <= s2e_pkg::mag33(y2_next);
            p1_reg <= pay_in;
        end
    end

    // squared lengths
    logic              v2_reg;
    s2e_pkg::cand_t    x1_2_reg, y1_2_reg, x2_2_reg, y2_2_reg;
    logic [63:0]       sq0_reg, sq1_reg, sq2_reg, sq3_reg;
    logic [PAY_W-1:0]  p2_reg;
    logic              big;
    logic [31:0]       h0, h1, h2, h3;

    assign big = m0_reg[32] | m0_reg[31] | m1_reg[32] | m1_reg[31]
               | m2_reg[32] | m2_reg[31] | m3_reg[32] | m3_reg[31];
    assign h0 = big ? m0_reg[32:1] : m0_reg[31:0];
    assign h1 = big ? m1_reg[32:1] : m1_reg[31:0];
    assign h2 = big ? m2_reg[32:1] : m2_reg[31:0];
    assign h3 = big ? m3_reg[32:1] : m3_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_2_reg <= x1_reg;
            y1_2_reg <= y1_reg;
            x2_2_reg <= x2_reg;
            y2_2_reg <= y2_reg;
            sq0_reg  <= 64'(h0) * 64'(h0);
            sq1_reg  <= 64'(h1) * 64'(h1);
            sq2_reg  <= 64'(h2) * 64'(h2);
            sq3_reg  <= 64'(h3) * 64'(h3);
            p2_reg   <= p1_reg;
        end
    end

    // pick the strictly longer candidate, else the second
    logic              v3_reg;
    s2e_pkg::cand_t    sx_reg, sy_reg;
    logic [PAY_W-1:0]  p3_reg;
    logic              first_longer;

    assign first_longer = (sq0_reg + sq1_reg) > (sq2_reg + sq3_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= first_longer ? x1_2_reg : x2_2_reg;
            sy_reg <= first_longer ? y1_2_reg : y2_2_reg;
            p3_reg <= p2_reg;
        end
    end

    // magnitudes and signs
    logic               v4_reg;
    s2e_pkg::cand_mag_t ux4_reg, uy4_reg, mx4_reg;
    logic               negx4_reg, negy4_reg;
    logic [PAY_W-1:0]   p4_reg;
    s2e_pkg::cand_mag_t ux4_next, uy4_next;

    assign ux4_next = s2e_pkg::mag33(sx_reg);
    assign uy4_next = s2e_pkg::mag33(sy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux4_reg   <= ux4_next;
            uy4_reg   <= uy4_next;
            mx4_reg   <= (ux4_next > uy4_next) ? ux4_next : uy4_next;
            negx4_reg <= sx_reg[s2e_pkg::CAND_W-1];
            negy4_reg <= sy_reg[s2e_pkg::CAND_W-1];
            p4_reg    <= p3_reg;
        end
    end

    // normalising shift amount
    logic               v5_reg;
    s2e_pkg::cand_mag_t ux5_reg, uy5_reg;
    logic               negx5_reg, negy5_reg, zero5_reg;
    logic [1:0]         rsh5_reg;
    logic [4:0]         lsh5_reg;
    logic [PAY_W-1:0]   p5_reg;
    logic [1:0]         rsh5_next;
    logic [4:0]         lsh5_next;

    always_comb
    begin
        lsh5_next = '0;
        for (int i = 0; i < 31; i++)
        begin
            if (mx4_reg[i])
                lsh5_next = 5'(30 - i);
        end
        if (mx4_reg[32])
            rsh5_next = 2'd2;
        else if (mx4_reg[31])
            rsh5_next = 2'd1;
        else
            rsh5_next = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux5_reg   <= ux4_reg;
            uy5_reg   <= uy4_reg;
            negx5_reg <= negx4_reg;
            negy5_reg <= negy4_reg;
            zero5_reg <= (mx4_reg == '0);
            rsh5_reg  <= rsh5_next;
            lsh5_reg  <= lsh5_next;
            p5_reg    <= p4_reg;
        end
    end

    // apply the shift
    logic               v6_reg;
    logic [30:0]        ux6_reg, uy6_reg;
    logic               negx6_reg, negy6_reg, zero6_reg;
    logic [PAY_W-1:0]   p6_reg;
    s2e_pkg::cand_mag_t uxs, uys;

    assign uxs = (rsh5_reg != 2'd0) ? (ux5_reg >> rsh5_reg) : (ux5_reg << lsh5_reg);
    assign uys = (rsh5_reg != 2'd0) ? (uy5_reg >> rsh5_reg) : (uy5_reg << lsh5_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux6_reg   <= uxs[30:0];
            uy6_reg   <= uys[30:0];
            negx6_reg <= negx5_reg;
            negy6_reg <= negy5_reg;
            zero6_reg <= zero5_reg;
            p6_reg    <= p5_reg;
        end
    end

    // squares of the normalised magnitudes
    logic               v7_reg;
    logic [61:0]        sqx7_reg, sqy7_reg;
    sq_pay_t            sp7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx7_reg     <= 62'(ux6_reg) * 62'(ux6_reg);
            sqy7_reg     <= 62'(uy6_reg) * 62'(uy6_reg);
            sp7_reg.ux   <= ux6_reg;
            sp7_reg.uy   <= uy6_reg;
            sp7_reg.negx <= negx6_reg;
            sp7_reg.negy <= negy6_reg;
            sp7_reg.zero <= zero6_reg;
            sp7_reg.pay  <= p6_reg;
        end
    end

    // sum of squares
    logic               v8_reg;
    logic [63:0]        sum8_reg;
    sq_pay_t            sp8_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else if (en)
            v8_reg <= v7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum8_reg <= 64'(sqx7_reg) + 64'(sqy7_reg);
            sp8_reg  <= sp7_reg;
        end
    end

    logic               sq_valid;
    logic [31:0]        norm;
    logic [$bits(sq_pay_t)-1:0] sq_pay_bits;
    sq_pay_t            sq_pay;

    s2e_isqrt_pipe #(
        .IN_W  (64),
        .PAY_W ($bits(sq_pay_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v8_reg),
        .radicand  (sum8_reg),
        .pay_in    (sp8_reg),
        .out_valid (sq_valid),
        .root      (norm),
        .pay_out   (sq_pay_bits)
    );

    assign sq_pay = sq_pay_t'(sq_pay_bits);

    // scaled dividends with half the divisor for rounding
    logic               v9_reg;
    logic [31:0]        den9_reg;
    logic [31:0]        remx9_reg, remy9_reg;
    logic [NQ-1:0]      lowx9_reg, lowy9_reg;
    dx_pay_t            dx9_reg;
    logic               negy9_reg;
    logic [45:0]        numx, numy;

    assign numx = (46'(sq_pay.ux) << s2e_pkg::FRAC_Q14) + 46'(norm >> 1);
    assign numy = (46'(sq_pay.uy) << s2e_pkg::FRAC_Q14) + 46'(norm >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v9_reg <= 1'b0;
        else if (en)
            v9_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den9_reg     <= norm;
            remx9_reg    <= 32'(numx[45:NQ]);
            remy9_reg    <= 32'(numy[45:NQ]);
            lowx9_reg    <= numx[NQ-1:0];
            lowy9_reg    <= numy[NQ-1:0];
            dx9_reg.negx <= sq_pay.negx;
            dx9_reg.zero <= sq_pay.zero;
            dx9_reg.pay  <= sq_pay.pay;
            negy9_reg    <= sq_pay.negy;
        end
    end

    logic                        dx_valid, dy_valid;
    logic [NQ-1:0]               qx, qy;
    logic [$bits(dx_pay_t)-1:0]  dx_bits;
    dx_pay_t                     dx_pay;
    logic                        negy_d;

    s2e_div_pipe #(
        .DEN_W (32),
        .QUO_W (NQ),
        .PAY_W ($bits(dx_pay_t))
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v9_reg),
        .rem_in    (remx9_reg),
        .num_in    (lowx9_reg),
        .den_in    (den9_reg),
        .pay_in    (dx9_reg),
        .out_valid (dx_valid),
        .quo       (qx),
        .pay_out   (dx_bits)
    );

    s2e_div_pipe #(
        .DEN_W (32),
        .QUO_W (NQ),
        .PAY_W (1)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v9_reg),
        .rem_in    (remy9_reg),
        .num_in    (lowy9_reg),
        .den_in    (den9_reg),
        .pay_in    (negy9_reg),
        .out_valid (dy_valid),
        .quo       (qy),
        .pay_out   (negy_d)
    );

    assign dx_pay = dx_pay_t'(dx_bits);

    // signed unit components
    logic               v10_reg;
    s2e_pkg::vec_t      vx10_reg, vy10_reg;
    logic [PAY_W-1:0]   p10_reg;
    s2e_pkg::vec_t      qx_s, qy_s;

    assign qx_s = s2e_pkg::vec_t'({1'b0, qx});
    assign qy_s = s2e_pkg::vec_t'({1'b0, qy});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v10_reg <= 1'b0;
        else if (en)
            v10_reg <= dx_valid & dy_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx10_reg <= dx_pay.zero ? '0 : (dx_pay.negx ? -qx_s : qx_s);
            vy10_reg <= dx_pay.zero ? '0 : (negy_d ? -qy_s : qy_s);
            p10_reg  <= dx_pay.pay;
        end
    end

    assign out_valid = v10_reg;
    assign vec_x     = vx10_reg;
    assign vec_y     = vy10_reg;
    assign pay_out   = p10_reg;

endmodule

// ----- rtl/symmetric_2x2_eigen_solver_core.sv -----
// Symmetric 2x2 eigen solver: one matrix per clock in, one result per clock out
// once the pipeline is full. On its way from input to output every transaction
// passes the 32-stage discriminant square root, the 64-stage second-eigenvalue
// divider, and per eigenvector a 32-stage length square root and a 15-stage
// component divider. All stages advance together and hold while the output
// register is full and not taken.
// depends on s2e_pkg, s2e_ifs, s2e_isqrt_pipe, s2e_div_pipe and s2e_eigvec
module symmetric_2x2_eigen_solver_core (
    input  logic        clk,
    input  logic        rst_n,
    s2e_in_if.sink      matrix,
    s2e_out_if.source   eigen
);

    typedef struct packed {
        s2e_pkg::data_t      a;
        s2e_pkg::data_t      b;
        s2e_pkg::data_t      c;
        logic signed [33:0]  s;
        logic signed [63:0]  qc;
        logic                sh;
    } root_pay_t;

    typedef struct packed {
        s2e_pkg::data_t                       a;
        s2e_pkg::data_t                       b;
        s2e_pkg::data_t                       c;
        logic signed [s2e_pkg::E1_W-1:0]      e1;
        logic [s2e_pkg::E1_MAG_W-1:0]         m1;
        logic                                 neg;
    } div_pay_t;

    typedef struct packed {
        s2e_pkg::data_t o1;
        s2e_pkg::data_t o2;
    } eig_pay_t;

    logic en;
    logic out_valid_reg;

    assign en           = !out_valid_reg || eigen.ready;
    assign matrix.ready = en;

    // input register
    logic           v0_reg;
    s2e_pkg::data_t a0_reg, b0_reg, c0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= matrix.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg <= matrix.var_x;
            b0_reg <= matrix.cov_xy;
            c0_reg <= matrix.var_y;
        end
    end

    // trace, products and discriminant terms
    logic               v1_reg;
    s2e_pkg::data_t     a1_reg, b1_reg, c1_reg;
    logic signed [33:0] s1_reg;
    logic signed [63:0] ac1_reg, bb1_reg;
    logic [32:0]        ud1_reg, ue1_reg;
    logic signed [32:0] d1;
    logic [31:0]        ub1;
    logic signed [63:0] ac1_next, bb1_next;

    assign d1       = 33'(a0_reg) - 33'(c0_reg);
    assign ub1      = b0_reg[31] ? 32'(-b0_reg) : 32'(b0_reg);
    assign ac1_next = 64'(a0_reg) * 64'(c0_reg);
    assign bb1_next = 64'(b0_reg) * 64'(b0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= a0_reg;
            b1_reg  <= b0_reg;
            c1_reg  <= c0_reg;
            s1_reg  <= 34'(a0_reg) + 34'(c0_reg);
            ac1_reg <= ac1_next;
            bb1_reg <= bb1_next;
            ud1_reg <= d1[32] ? 33'(-d1) : 33'(d1);
            ue1_reg <= {ub1, 1'b0};
        end
    end

    // determinant and squared terms
    logic               v2_reg;
    s2e_pkg::data_t     a2_reg, b2_reg, c2_reg;
    logic signed [33:0] s2_reg;
    logic signed [63:0] qc2_reg;
    logic               sh2_reg;
    logic [63:0]        sqd2_reg, sqe2_reg;
    logic               sh2_next;
    logic [31:0]        uds, ues;

    assign sh2_next = ud1_reg[32] | ud1_reg[31] | ue1_reg[32] | ue1_reg[31];
    assign uds      = sh2_next ? ud1_reg[32:1] : ud1_reg[31:0];
    assign ues      = sh2_next ? ue1_reg[32:1] : ue1_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            c2_reg   <= c1_reg;
            s2_reg   <= s1_reg;
            qc2_reg  <= ac1_reg - bb1_reg;
            sh2_reg  <= sh2_next;
            sqd2_reg <= 64'(uds) * 64'(uds);
            sqe2_reg <= 64'(ues) * 64'(ues);
        end
    end

    // discriminant
    logic        v3_reg;
    logic [63:0] disc3_reg;
    root_pay_t   rp3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disc3_reg  <= sqd2_reg + sqe2_reg;
            rp3_reg.a  <= a2_reg;
            rp3_reg.b  <= b2_reg;
            rp3_reg.c  <= c2_reg;
            rp3_reg.s  <= s2_reg;
            rp3_reg.qc <= qc2_reg;
            rp3_reg.sh <= sh2_reg;
        end
    end

    logic                         rt_valid;
    logic [31:0]                  rt;
    logic [$bits(root_pay_t)-1:0] rt_bits;
    root_pay_t                    rt_pay;

    s2e_isqrt_pipe #(
        .IN_W  (64),
        .PAY_W ($bits(root_pay_t))
    ) u_disc_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .radicand  (disc3_reg),
        .pay_in    (rp3_reg),
        .out_valid (rt_valid),
        .root      (rt),
        .pay_out   (rt_bits)
    );

    assign rt_pay = root_pay_t'(rt_bits);

    // q form numerator
    logic               v4_reg;
    logic signed [35:0] q4_reg;
    s2e_pkg::data_t     a4_reg, b4_reg, c4_reg;
    logic signed [63:0] qc4_reg;
    logic [33:0]        rootsh;
    logic signed [35:0] s_x, r_x;

    assign rootsh = 34'(rt) << rt_pay.sh;
    assign s_x    = 36'(rt_pay.s);
    assign r_x    = 36'(signed'({1'b0, rootsh}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= rt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q4_reg  <= (rt_pay.s > 0) ? s_x + r_x : s_x - r_x;
            a4_reg  <= rt_pay.a;
            b4_reg  <= rt_pay.b;
            c4_reg  <= rt_pay.c;
            qc4_reg <= rt_pay.qc;
        end
    end

    // first eigenvalue, halved toward zero, and divider operands
    logic                            v5_reg;
    logic [63:0]                     mqc5_reg;
    div_pay_t                        dp5_reg;
    logic signed [35:0]              q_adj;
    logic signed [s2e_pkg::E1_W-1:0] e1_5;

    assign q_adj = q4_reg + 36'(q4_reg[35]);
    assign e1_5  = s2e_pkg::E1_W'(q_adj >>> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mqc5_reg    <= qc4_reg[63] ? 64'(-qc4_reg) : 64'(qc4_reg);
            dp5_reg.a   <= a4_reg;
            dp5_reg.b   <= b4_reg;
            dp5_reg.c   <= c4_reg;
            dp5_reg.e1  <= e1_5;
            dp5_reg.m1  <= e1_5[s2e_pkg::E1_W-1] ? s2e_pkg::E1_MAG_W'(-e1_5)
                                                 : s2e_pkg::E1_MAG_W'(e1_5);
            dp5_reg.neg <= qc4_reg[63] ^ e1_5[s2e_pkg::E1_W-1];
        end
    end

    logic                        dv_valid;
    logic [63:0]                 quo;
    logic [$bits(div_pay_t)-1:0] dv_bits;
    div_pay_t                    dv_pay;

    s2e_div_pipe #(
        .DEN_W (s2e_pkg::E1_MAG_W),
        .QUO_W (64),
        .PAY_W ($bits(div_pay_t))
    ) u_second_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .rem_in    ('0),
        .num_in    (mqc5_reg),
        .den_in    (dp5_reg.m1),
        .pay_in    (dp5_reg),
        .out_valid (dv_valid),
        .quo       (quo),
        .pay_out   (dv_bits)
    );

    assign dv_pay = div_pay_t'(dv_bits);

    // second eigenvalue; a single root is duplicated
    logic                                   v6_reg;
    s2e_pkg::data_t                         a6_reg, b6_reg, c6_reg;
    logic signed [s2e_pkg::E1_W-1:0]        e1_6_reg;
    logic [s2e_pkg::E1_MAG_W-1:0]           m1_6_reg;
    logic signed [63:0]                     e2_6_reg;
    logic [s2e_pkg::RATIO_CLAMP_W-1:0]      m2c6_reg;
    logic                                   e1_zero;
    logic                                   quo_big;

    assign e1_zero = (dv_pay.m1 == '0);
    assign quo_big = (quo[63:s2e_pkg::RATIO_CLAMP_W-1] != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a6_reg   <= dv_pay.a;
            b6_reg   <= dv_pay.b;
            c6_reg   <= dv_pay.c;
            e1_6_reg <= dv_pay.e1;
            m1_6_reg <= dv_pay.m1;
            e2_6_reg <= e1_zero ? '0 : (dv_pay.neg ? -$signed(quo) : $signed(quo));
            m2c6_reg <= quo_big ? {1'b1, {(s2e_pkg::RATIO_CLAMP_W-1){1'b0}}}
                                : quo[s2e_pkg::RATIO_CLAMP_W-1:0];
        end
    end

    // ratio cross products
    logic               v7_reg;
    s2e_pkg::data_t     a7_reg, b7_reg, c7_reg;
    logic signed [s2e_pkg::E1_W-1:0] e1_7_reg;
    logic signed [63:0] e2_7_reg;
    logic [54:0]        pm2_7_reg;
    logic [47:0]        plo7_reg, phi7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a7_reg    <= a6_reg;
            b7_reg    <= b6_reg;
            c7_reg    <= c6_reg;
            e1_7_reg  <= e1_6_reg;
            e2_7_reg  <= e2_6_reg;
            pm2_7_reg <= 55'(m2c6_reg) * 55'(s2e_pkg::RATIO_SCALE);
            plo7_reg  <= 48'(m1_6_reg) * 48'(s2e_pkg::RATIO_LO);
            phi7_reg  <= 48'(m1_6_reg) * 48'(s2e_pkg::RATIO_HI);
        end
    end

    // fallback decision and saturated eigenvalues
    logic           v8_reg;
    s2e_pkg::data_t a8_reg, b8_reg, c8_reg, o1_8_reg, o2_8_reg;
    logic           fb8_reg;
    logic           fb_next;

    assign fb_next = (a7_reg <= 32'sd0)
                   || ((e1_7_reg != '0)
                       && (pm2_7_reg > 55'(plo7_reg))
                       && (pm2_7_reg < 55'(phi7_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else if (en)
            v8_reg <= v7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a8_reg   <= a7_reg;
            b8_reg   <= b7_reg;
            c8_reg   <= c7_reg;
            fb8_reg  <= fb_next;
            o1_8_reg <= fb_next ? a7_reg : s2e_pkg::sat32(64'(e1_7_reg));
            o2_8_reg <= fb_next ? a7_reg : s2e_pkg::sat32(e2_7_reg);
        end
    end

    // eigenvectors
    logic                        ev1_valid, ev2_valid;
    s2e_pkg::vec_t               v1x, v1y, v2x, v2y;
    eig_pay_t                    ep_in;
    logic [$bits(eig_pay_t)-1:0] ep_bits;
    eig_pay_t                    ep_out;
    logic                        fb_d;

    assign ep_in.o1 = o1_8_reg;
    assign ep_in.o2 = o2_8_reg;

    s2e_eigvec #(
        .PAY_W ($bits(eig_pay_t))
    ) u_vec_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v8_reg),
        .a         (a8_reg),
        .b         (b8_reg),
        .c         (c8_reg),
        .lam       (o1_8_reg),
        .pay_in    (ep_in),
        .out_valid (ev1_valid),
        .vec_x     (v1x),
        .vec_y     (v1y),
        .pay_out   (ep_bits)
    );

    s2e_eigvec #(
        .PAY_W (1)
    ) u_vec_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v8_reg),
        .a         (a8_reg),
        .b         (b8_reg),
        .c         (c8_reg),
        .lam       (o2_8_reg),
        .pay_in    (fb8_reg),
        .out_valid (ev2_valid),
        .vec_x     (v2x),
        .vec_y     (v2y),
        .pay_out   (fb_d)
    );

    assign ep_out = eig_pay_t'(ep_bits);

    // output register
    s2e_pkg::data_t e1_out_reg, e2_out_reg;
    s2e_pkg::vec_t  v1x_reg, v1y_reg, v2x_reg, v2y_reg;
    logic           fb_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= ev1_valid & ev2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_out_reg <= ep_out.o1;
            e2_out_reg <= ep_out.o2;
            fb_out_reg <= fb_d;
            v1x_reg    <= fb_d ? s2e_pkg::vec_t'(s2e_pkg::ONE_Q14) : v1x;
            v1y_reg    <= fb_d ? '0 : v1y;
            v2x_reg    <= fb_d ? '0 : v2x;
            v2y_reg    <= fb_d ? s2e_pkg::vec_t'(s2e_pkg::ONE_Q14) : v2y;
        end
    end

    assign eigen.valid         = out_valid_reg;
    assign eigen.eigen_first   = e1_out_reg;
    assign eigen.eigen_second  = e2_out_reg;
    assign eigen.vec_first_x   = v1x_reg;
    assign eigen.vec_first_y   = v1y_reg;
    assign eigen.vec_second_x  = v2x_reg;
    assign eigen.vec_second_y  = v2y_reg;
    assign eigen.used_fallback = fb_out_reg;

endmodule
